@@ rtl/slwl_pkg.sv @@
// shared types, sizes and codes for the per-source sliding window limiter
// no dependencies; every other file depends on this package
package slwl_pkg;

    localparam int SOURCES   = 64;
    localparam int LOG_DEPTH = 16;

    localparam int SLOT_W    = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam int SCAN_W    = $clog2(SOURCES + 1);
    localparam int PTR_W     = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CNT_W     = $clog2(LOG_DEPTH + 1);
    localparam int TADDR_W   = (SOURCES * LOG_DEPTH > 1) ? $clog2(SOURCES * LOG_DEPTH) : 1;
    localparam int MAXREQ_W  = 5;
    localparam int LIM_W     = (CNT_W > MAXREQ_W) ? CNT_W : MAXREQ_W;
    localparam int TIME_W    = 32;
    localparam int ADDR_W    = 64;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] ACT_REQUEST   = 2'd0;
    localparam logic [1:0] ACT_CLEAR_ONE = 2'd1;
    localparam logic [1:0] ACT_CLEAR_ALL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_REQUESTS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS = CFG_IDX_W'(1);

    localparam logic [MAXREQ_W-1:0] MAX_REQUESTS_RESET = MAXREQ_W'(16);
    localparam logic [TIME_W-1:0]   WINDOW_TICKS_RESET = TIME_W'(60);

    typedef enum logic [1:0] {
        OP_REQUEST,
        OP_CLEAR_ONE,
        OP_CLEAR_ALL,
        OP_NOP
    } op_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [ADDR_W-1:0] source_addr_hi;
        logic [ADDR_W-1:0] source_addr_lo;
        logic [TIME_W-1:0] now_ticks;
    } req_t;

    typedef struct packed {
        logic              allowed;
        logic [4:0]        request_count;
        logic [TIME_W-1:0] ticks_until_reset;
        logic              table_full;
    } rsp_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [TIME_W-1:0]    data;
    } cfg_t;

    typedef struct packed {
        op_t                 op;
        logic [2*ADDR_W-1:0] key;
        logic [TIME_W-1:0]   now;
    } job_t;

    function automatic logic [TADDR_W-1:0] time_addr(input logic [SLOT_W-1:0] slot,
                                                     input logic [PTR_W-1:0] ptr);
        return TADDR_W'(32'(slot) * LOG_DEPTH + 32'(ptr));
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        return (32'(ptr) == LOG_DEPTH - 1) ? '0 : PTR_W'(32'(ptr) + 1);
    endfunction

endpackage

@@ rtl/slwl_if.sv @@
// valid/ready channel interfaces for requests, results and configuration writes
// depends on slwl_pkg
interface slwl_req_if;
    logic              valid;
    logic              ready;
    slwl_pkg::req_t    payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface slwl_rsp_if;
    logic              valid;
    logic              ready;
    slwl_pkg::rsp_t    payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface slwl_cfg_if;
    logic              valid;
    logic              ready;
    slwl_pkg::cfg_t    payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/slwl_front.sv @@
// front stage: takes request transfers and decodes the action into a job
// depends on slwl_pkg and slwl_if
module slwl_front (
    input  logic            clk,
    input  logic            rst_n,
    slwl_req_if.sink        req,
    output logic            push_valid,
    input  logic            push_ready,
    output slwl_pkg::job_t  push_data
);
    import slwl_pkg::*;

    logic vld_reg;
    job_t job_reg;
    op_t  op_dec;

    always_comb
    begin
        case (req.payload.action)
            ACT_REQUEST:   op_dec = OP_REQUEST;
            ACT_CLEAR_ONE: op_dec = OP_CLEAR_ONE;
            ACT_CLEAR_ALL: op_dec = OP_CLEAR_ALL;
            default:       op_dec = OP_NOP;
        endcase
    end

    assign req.ready  = !vld_reg || push_ready;
    assign push_valid = vld_reg;
    assign push_data  = job_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            vld_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            job_reg.op  <= op_dec;
            job_reg.key <= {req.payload.source_addr_hi, req.payload.source_addr_lo};
            job_reg.now <= req.payload.now_ticks;
        end
    end

endmodule

@@ rtl/slwl_queue.sv @@
// two-entry job queue between the front stage and the engine
// depends on slwl_pkg
module slwl_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  slwl_pkg::job_t  push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output slwl_pkg::job_t  pop_data
);
    import slwl_pkg::*;

    job_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/slwl_engine.sv @@
// back end: source table scan, ring expiry walk, append and result register
// depends on slwl_pkg and slwl_if
module slwl_engine (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      pop_valid,
    output logic                      pop_ready,
    input  slwl_pkg::job_t            pop_data,
    input  logic [slwl_pkg::LIM_W-1:0]  limit,
    input  logic [slwl_pkg::TIME_W-1:0] window,
    slwl_rsp_if.source                rsp
);
    import slwl_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_CLAIM,
        S_HC_RD,
        S_HC_LD,
        S_WALK_RD,
        S_WALK_CHK,
        S_APPEND,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic [PTR_W-1:0] head;
        logic [CNT_W-1:0] count;
    } ring_t;

    state_t              state_reg;
    job_t                job_reg;
    logic [SOURCES-1:0]  slot_valid_reg;
    logic [SCAN_W-1:0]   scan_idx_reg;
    logic [SLOT_W-1:0]   cmp_idx_reg;
    logic                cmp_vld_reg;
    logic                free_found_reg;
    logic [SLOT_W-1:0]   free_idx_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [PTR_W-1:0]    head_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [TIME_W-1:0]   age_reg;
    rsp_t                res_reg;
    logic                out_vld_reg;
    rsp_t                out_reg;

    logic [2*ADDR_W-1:0] key_mem [SOURCES];
    logic [2*ADDR_W-1:0] key_rd_reg;
    ring_t               hc_mem [SOURCES];
    ring_t               hc_rd_reg;
    logic [TIME_W-1:0]   tm_mem [SOURCES*LOG_DEPTH];
    logic [TIME_W-1:0]   tm_rd_reg;

    logic                key_hit;
    logic                cmp_free;
    logic                scan_last;
    logic                free_now;
    logic [SLOT_W-1:0]   free_idx_now;
    logic                append_ok;
    logic [CNT_W-1:0]    count_new;
    logic [CNT_W:0]      tail_sum;
    logic [PTR_W-1:0]    tail;
    logic [TIME_W-1:0]   walk_age;
    logic [TIME_W-1:0]   oldest_age;
    logic [TIME_W-1:0]   ticks;
    logic                out_load;

    always_comb
    begin
        key_hit      = cmp_vld_reg && slot_valid_reg[cmp_idx_reg] && (key_rd_reg == job_reg.key);
        cmp_free     = cmp_vld_reg && !slot_valid_reg[cmp_idx_reg];
        scan_last    = cmp_vld_reg && (32'(cmp_idx_reg) == SOURCES - 1);
        free_now     = free_found_reg || cmp_free;
        free_idx_now = free_found_reg ? free_idx_reg : cmp_idx_reg;
        append_ok    = (LIM_W'(count_reg) < limit);
        count_new    = count_reg + CNT_W'(append_ok);
        tail_sum     = (CNT_W+1)'(head_reg) + (CNT_W+1)'(count_reg);
        tail         = (32'(tail_sum) >= LOG_DEPTH) ? PTR_W'(32'(tail_sum) - LOG_DEPTH)
                                                    : PTR_W'(tail_sum);
        walk_age     = job_reg.now - tm_rd_reg;
        oldest_age   = (count_reg == '0) ? '0 : age_reg;
        ticks        = ((count_new != '0) && (oldest_age < window)) ? window - oldest_age : '0;
        out_load     = (state_reg == S_RESULT) && (!out_vld_reg || rsp.ready);
    end

    assign pop_ready   = (state_reg == S_IDLE);
    assign rsp.valid   = out_vld_reg;
    assign rsp.payload = out_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLAIM)
        begin
            key_mem[slot_reg] <= job_reg.key;
        end
        key_rd_reg <= key_mem[scan_idx_reg[SLOT_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_APPEND)
        begin
            hc_mem[slot_reg] <= '{head: head_reg, count: count_new};
        end
        hc_rd_reg <= hc_mem[slot_reg];
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_APPEND) && append_ok)
        begin
            tm_mem[time_addr(slot_reg, tail)] <= job_reg.now;
        end
        tm_rd_reg <= tm_mem[time_addr(slot_reg, head_reg)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            slot_valid_reg <= '0;
            out_vld_reg    <= 1'b0;
            cmp_vld_reg    <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
                out_reg     <= res_reg;
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (pop_valid)
                    begin
                        job_reg        <= pop_data;
                        scan_idx_reg   <= '0;
                        cmp_vld_reg    <= 1'b0;
                        free_found_reg <= 1'b0;
                        case (pop_data.op)
                            OP_REQUEST, OP_CLEAR_ONE:
                            begin
                                res_reg   <= '0;
                                state_reg <= S_SCAN;
                            end
                            OP_CLEAR_ALL:
                            begin
                                slot_valid_reg <= '0;
                                res_reg        <= '{allowed: 1'b1, default: '0};
                                state_reg      <= S_RESULT;
                            end
                            default:
                            begin
                                res_reg   <= '0;
                                state_reg <= S_RESULT;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (32'(scan_idx_reg) < SOURCES)
                    begin
                        cmp_idx_reg  <= scan_idx_reg[SLOT_W-1:0];
                        scan_idx_reg <= scan_idx_reg + SCAN_W'(1);
                    end
                    cmp_vld_reg <= (32'(scan_idx_reg) < SOURCES) && !key_hit && !scan_last;
                    if (cmp_free && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= cmp_idx_reg;
                    end
                    if (key_hit)
                    begin
                        slot_reg <= cmp_idx_reg;
                        if (job_reg.op == OP_CLEAR_ONE)
                        begin
                            slot_valid_reg[cmp_idx_reg] <= 1'b0;
                            res_reg.allowed             <= 1'b1;
                            state_reg                   <= S_RESULT;
                        end
                        else
                        begin
                            state_reg <= S_HC_RD;
                        end
                    end
                    else if (scan_last)
                    begin
                        if (job_reg.op == OP_CLEAR_ONE)
                        begin
                            res_reg.allowed <= 1'b1;
                            state_reg       <= S_RESULT;
                        end
                        else if (free_now)
                        begin
                            slot_reg  <= free_idx_now;
                            state_reg <= S_CLAIM;
                        end
                        else
                        begin
                            res_reg.table_full <= 1'b1;
                            state_reg          <= S_RESULT;
                        end
                    end
                end
                S_CLAIM:
                begin
                    slot_valid_reg[slot_reg] <= 1'b1;
                    head_reg                 <= '0;
                    count_reg                <= '0;
                    state_reg                <= S_APPEND;
                end
                S_HC_RD:
                begin
                    state_reg <= S_HC_LD;
                end
                S_HC_LD:
                begin
                    head_reg  <= hc_rd_reg.head;
                    count_reg <= hc_rd_reg.count;
                    state_reg <= (hc_rd_reg.count == '0) ? S_APPEND : S_WALK_RD;
                end
                S_WALK_RD:
                begin
                    state_reg <= S_WALK_CHK;
                end
                S_WALK_CHK:
                begin
                    if (walk_age > window)
                    begin
                        head_reg  <= ptr_inc(head_reg);
                        count_reg <= count_reg - CNT_W'(1);
                        state_reg <= (count_reg == CNT_W'(1)) ? S_APPEND : S_WALK_RD;
                    end
                    else
                    begin
                        age_reg   <= walk_age;
                        state_reg <= S_APPEND;
                    end
                end
                S_APPEND:
                begin
                    res_reg.allowed           <= append_ok;
                    res_reg.request_count     <= 5'(count_new);
                    res_reg.ticks_until_reset <= ticks;
                    res_reg.table_full        <= 1'b0;
                    state_reg                 <= S_RESULT;
                end
                S_RESULT:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/per_source_sliding_window_limiter.sv @@
// Per-source sliding window request limiter, top level.
// Channels: req carries action, 128-bit source address and now_ticks; rsp
// returns allowed, request_count, ticks_until_reset and table_full, one
// result per request transfer, in order. cfg writes max_requests (index 0)
// and window_ticks (index 1); it is always ready.
// A front stage decodes each transfer into a job and a two-entry queue
// feeds the engine, which handles one job at a time.
// The engine scans the source table one slot per cycle and stops at a hit.
// A new source, a full table or an unknown clear scan the whole table; a
// known clear or request stops at its slot s, and a known request then
// examines its logged times from the oldest, up to LOG_DEPTH of them.
// Clear all and the unused action code skip the scan. The engine takes no
// new job until the result of the last one has entered the output register.
// Reset empties the table and loads max_requests 16 and window_ticks 60;
// no clearing pass is needed. When rsp stalls, the result waits in the
// output register, the engine finishes the next job and holds it, and the
// queue fills until req ready drops.
// depends on slwl_pkg, slwl_if, slwl_front, slwl_queue, slwl_engine
module per_source_sliding_window_limiter (
    input  logic        clk,
    input  logic        rst_n,
    slwl_req_if.sink    req,
    slwl_rsp_if.source  rsp,
    slwl_cfg_if.sink    cfg
);
    import slwl_pkg::*;

    logic [MAXREQ_W-1:0] max_requests_reg;
    logic [TIME_W-1:0]   window_ticks_reg;
    logic [LIM_W-1:0]    limit;
    logic                push_valid;
    logic                push_ready;
    job_t                push_data;
    logic                pop_valid;
    logic                pop_ready;
    job_t                pop_data;

    assign cfg.ready = 1'b1;
    assign limit     = (32'(max_requests_reg) > LOG_DEPTH) ? LIM_W'(LOG_DEPTH)
                                                           : LIM_W'(max_requests_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_requests_reg <= MAX_REQUESTS_RESET;
            window_ticks_reg <= WINDOW_TICKS_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.payload.index)
                REG_MAX_REQUESTS: max_requests_reg <= cfg.payload.data[MAXREQ_W-1:0];
                REG_WINDOW_TICKS: window_ticks_reg <= cfg.payload.data;
                default:          ;
            endcase
        end
    end

    slwl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    slwl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    slwl_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .limit     (limit),
        .window    (window_ticks_reg),
        .rsp       (rsp)
    );

    a_full_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.payload.table_full |->
            !rsp.payload.allowed && (rsp.payload.request_count == 5'd0)
            && (rsp.payload.ticks_until_reset == '0))
        else $error("table full result carries data");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (32'(rsp.payload.request_count) <= LOG_DEPTH))
        else $error("request count above ring depth");

    a_ticks_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.payload.ticks_until_reset <= window_ticks_reg))
        else $error("ticks until reset above window");

    a_no_early_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !rsp.valid)
        else $error("result right after reset");

endmodule

@@ sim/testbench.sv @@
// self-checking testbench for per_source_sliding_window_limiter
// depends on slwl_pkg, slwl_if and the limiter rtl; predicts every result in-line
module testbench;
    import slwl_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 150;

    typedef struct {
        logic [1:0]  action;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [31:0] now;
        bit          typed;
        rsp_t        result;
    } stim_row_t;

    logic clk;
    logic rst_n;

    slwl_req_if req_ch();
    slwl_rsp_if rsp_ch();
    slwl_cfg_if cfg_ch();

    per_source_sliding_window_limiter DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // limiter state mirror
    logic [63:0] mirror_hi    [SOURCES];
    logic [63:0] mirror_lo    [SOURCES];
    bit          mirror_used  [SOURCES];
    logic [31:0] mirror_times [SOURCES][LOG_DEPTH];
    int          mirror_head  [SOURCES];
    int          mirror_count [SOURCES];
    logic [4:0]  cur_max_requests;
    logic [31:0] cur_window;

    rsp_t        pending_results[$];
    int          mismatches = 0;
    int          cycles = 0;
    int          sender_idle;
    int          receiver_idle;

    function automatic rsp_t window_predict(req_t r);
        rsp_t        res;
        int          slot;
        int          limit;
        logic [31:0] age;
        res = '0;
        slot = -1;
        if (r.action == ACT_CLEAR_ALL)
        begin
            for (int s = 0; s < SOURCES; s++)
            begin
                mirror_used[s] = 0;
                mirror_head[s] = 0;
                mirror_count[s] = 0;
            end
            res.allowed = 1'b1;
            return res;
        end
        if (r.action != ACT_REQUEST && r.action != ACT_CLEAR_ONE)
            return res;
        for (int s = 0; s < SOURCES; s++)
            if (slot < 0 && mirror_used[s] && mirror_hi[s] == r.source_addr_hi
                && mirror_lo[s] == r.source_addr_lo)
                slot = s;
        if (r.action == ACT_CLEAR_ONE)
        begin
            if (slot >= 0)
            begin
                mirror_used[slot] = 0;
                mirror_head[slot] = 0;
                mirror_count[slot] = 0;
            end
            res.allowed = 1'b1;
            return res;
        end
        for (int s = 0; s < SOURCES; s++)
            if (slot < 0 && !mirror_used[s])
            begin
                slot = s;
                mirror_used[s] = 1;
                mirror_hi[s] = r.source_addr_hi;
                mirror_lo[s] = r.source_addr_lo;
                mirror_head[s] = 0;
                mirror_count[s] = 0;
            end
        if (slot < 0)
        begin
            res.table_full = 1'b1;
            return res;
        end
        // expire from the front of the ring
        while (mirror_count[slot] > 0)
        begin
            age = r.now_ticks - mirror_times[slot][mirror_head[slot]];
            if (age <= cur_window)
                break;
            mirror_head[slot] = (mirror_head[slot] + 1) % LOG_DEPTH;
            mirror_count[slot]--;
        end
        limit = (cur_max_requests < LOG_DEPTH) ? int'(cur_max_requests) : LOG_DEPTH;
        if (mirror_count[slot] < limit)
        begin
            mirror_times[slot][(mirror_head[slot] + mirror_count[slot]) % LOG_DEPTH]
                = r.now_ticks;
            mirror_count[slot]++;
            res.allowed = 1'b1;
        end
        if (mirror_count[slot] > 0)
        begin
            age = r.now_ticks - mirror_times[slot][mirror_head[slot]];
            if (age < cur_window)
                res.ticks_until_reset = cur_window - age;
        end
        res.request_count = 5'(mirror_count[slot]);
        return res;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    // result side: check then pick the next ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer: %p", rsp_ch.payload);
                end
                else
                begin
                    rsp_t want;
                    want = pending_results[0];
                    pending_results.delete(0);
                    if (rsp_ch.payload.allowed !== want.allowed
                        || rsp_ch.payload.request_count !== want.request_count
                        || rsp_ch.payload.ticks_until_reset !== want.ticks_until_reset
                        || rsp_ch.payload.table_full !== want.table_full)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected %p actual %p",
                                     want, rsp_ch.payload);
                    end
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= receiver_idle);
        end
    end

    task automatic send_item(input req_t r, input bit typed, input rsp_t typed_result);
        rsp_t predicted;
        if ($urandom_range(99) < sender_idle)
        begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle);
        end
        req_ch.valid <= 1'b1;
        req_ch.payload <= r;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = window_predict(r);
        pending_results.insert(pending_results.size(), typed ? typed_result : predicted);
    endtask

    task automatic send_request(input logic [1:0] act, input logic [63:0] hi,
                                input logic [63:0] lo, input logic [31:0] now);
        req_t r;
        r.action = act;
        r.source_addr_hi = hi;
        r.source_addr_lo = lo;
        r.now_ticks = now;
        send_item(r, 1'b0, '0);
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.payload <= '{index: idx, data: value};
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == REG_MAX_REQUESTS)
            cur_max_requests = value[4:0];
        else if (idx == REG_WINDOW_TICKS)
            cur_window = value;
        @(posedge clk);
    endtask

    initial
    begin
        stim_row_t   rows[$];
        stim_row_t   row;
        req_t        r;
        logic [63:0] pool_hi[80];
        logic [63:0] pool_lo[80];
        logic [31:0] now;
        logic [31:0] max_list[6];
        logic [31:0] win_list[6];
        int          pool_size;
        int          pick;
        int          sel;
        logic [1:0]  act;

        req_ch.valid <= 1'b0;
        req_ch.payload <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.payload <= '0;
        sender_idle = 24;
        receiver_idle = 76;
        cur_max_requests = MAX_REQUESTS_RESET;
        cur_window = WINDOW_TICKS_RESET;
        for (int s = 0; s < SOURCES; s++)
        begin
            mirror_used[s] = 0;
            mirror_head[s] = 0;
            mirror_count[s] = 0;
            mirror_hi[s] = '0;
            mirror_lo[s] = '0;
        end

        rows = '{
            '{ACT_REQUEST, 64'd0, 64'd1, 32'd1000, 1, '{1'b1, 5'd1, 32'd60, 1'b0}},
            '{ACT_REQUEST, 64'd0, 64'd1, 32'd1010, 0, '0},
            '{ACT_REQUEST, 64'd0, 64'd1, 32'd1071, 0, '0},
            '{ACT_REQUEST, 64'd0, 64'd1, 32'd1071, 0, '0},
            '{OP_NOP, 64'd0, 64'd1, 32'd1072, 1, '{1'b0, 5'd0, 32'd0, 1'b0}},
            '{ACT_CLEAR_ONE, 64'd5, 64'd5, 32'd1073, 1, '{1'b1, 5'd0, 32'd0, 1'b0}},
            '{ACT_REQUEST, 64'd0, 64'd1, 32'd1074, 0, '0},
            '{ACT_CLEAR_ONE, 64'd0, 64'd1, 32'd1075, 1, '{1'b1, 5'd0, 32'd0, 1'b0}},
            '{ACT_REQUEST, 64'd0, 64'd1, 32'd1076, 1, '{1'b1, 5'd1, 32'd60, 1'b0}},
            '{ACT_REQUEST, '1, '1, '1, 1, '{1'b1, 5'd1, 32'd60, 1'b0}},
            '{ACT_REQUEST, '1, '1, 32'd0, 0, '0},
            '{ACT_REQUEST, '1, '1, 32'd59, 0, '0},
            '{ACT_REQUEST, '1, '1, 32'd61, 0, '0},
            '{ACT_CLEAR_ALL, '1, '1, 32'd62, 1, '{1'b1, 5'd0, 32'd0, 1'b0}},
            '{ACT_REQUEST, '1, 64'd0, 32'd0, 1, '{1'b1, 5'd1, 32'd60, 1'b0}},
            '{ACT_REQUEST, 64'd0, 64'd1, 32'd0, 1, '{1'b1, 5'd1, 32'd60, 1'b0}}
        };
        for (int i = 0; i < 17; i++)
        begin
            row.action = ACT_REQUEST;
            row.hi = 64'd7;
            row.lo = 64'd7;
            row.now = 32'(100 + i);
            row.typed = 1'b0;
            row.result = '0;
            rows.insert(rows.size(), row);
        end

        @(posedge clk);
        while (!rst_n)
            @(posedge clk);

        foreach (rows[i])
        begin
            row = rows[i];
            r.action = row.action;
            r.source_addr_hi = row.hi;
            r.source_addr_lo = row.lo;
            r.now_ticks = row.now;
            send_item(r, row.typed, row.result);
        end

        // fill the table until a new source is turned away
        for (int i = 0; i < SOURCES + 2; i++)
            send_request(ACT_REQUEST, 64'(i + 100), 64'(i * 3), 32'(200 + i));
        send_request(ACT_REQUEST, 64'd0, 64'd1, 32'd300);
        send_request(ACT_CLEAR_ALL, 64'd0, 64'd0, 32'd301);

        max_list = '{32'd1, 32'd0, 32'd31, 32'd4, 32'hFFFF_FFF0, 32'd16};
        win_list = '{32'd1, 32'd5, 32'd100, 32'd0, 32'hFFFF_FFFF, 32'd60};
        for (int p = 0; p < 6; p++)
        begin
            drain_results();
            if (p == 5)
            begin
                max_list[p] = $urandom_range(1, 16);
                win_list[p] = $urandom_range(1, 200);
            end
            write_register(REG_MAX_REQUESTS, max_list[p]);
            write_register(REG_WINDOW_TICKS, win_list[p]);
            sender_idle = (p < 2) ? 24 : (p < 4) ? 76 : 0;
            receiver_idle = (p < 2) ? 76 : (p < 4) ? 24 : 0;
            pool_size = ($urandom_range(1)) ? 6 : 80;
            for (int k = 0; k < 80; k++)
            begin
                pool_hi[k] = ($urandom_range(3) == 0) ? 64'd0 : {$urandom, $urandom};
                pool_lo[k] = {$urandom, $urandom};
            end
            now = $urandom;
            for (int n = 0; n < 180; n++)
            begin
                case ($urandom_range(3))
                    0: now = now;
                    1: now = now + $urandom_range(3);
                    2: now = now + $urandom_range(40);
                    default: now = ($urandom_range(7) == 0) ? $urandom : now + 1;
                endcase
                sel = $urandom_range(99);
                act = (sel < 86) ? ACT_REQUEST : (sel < 94) ? ACT_CLEAR_ONE
                    : (sel < 97) ? ACT_CLEAR_ALL : OP_NOP;
                pick = $urandom_range(pool_size - 1);
                if ($urandom_range(19) == 0)
                    send_request(act, {$urandom, $urandom}, {$urandom, $urandom}, now);
                else
                    send_request(act, pool_hi[pick], pool_lo[pick], now);
            end
        end

        drain_results();
        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
